>>> rtl/cie_pkg.sv
// Shared types, operation and result codes, and position arithmetic for the
// CIGAR interval extractor. No dependencies.

package cie_pkg;

	// Largest reference or query position; positions saturate here
	localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

	// Reset value of the minimum splice flank register
	localparam logic [27:0] MIN_FLANK_RST = 28'd3;

	// Operation codes
	localparam logic [3:0] OP_M  = 4'd0;
	localparam logic [3:0] OP_I  = 4'd1;
	localparam logic [3:0] OP_D  = 4'd2;
	localparam logic [3:0] OP_N  = 4'd3;
	localparam logic [3:0] OP_S  = 4'd4;
	localparam logic [3:0] OP_EQ = 4'd7;
	localparam logic [3:0] OP_X  = 4'd8;

	// Result kinds
	localparam logic [2:0] KIND_MATCH  = 3'd0;
	localparam logic [2:0] KIND_INS    = 3'd1;
	localparam logic [2:0] KIND_DEL    = 3'd2;
	localparam logic [2:0] KIND_SPLICE = 3'd3;
	localparam logic [2:0] KIND_SUMM   = 3'd4;

	// Most results one operation can cause
	localparam int MAX_RES = 3;

	// One input operation
	typedef struct packed {
		logic [3:0]  code;
		logic [27:0] length;
		logic [30:0] align_start;
		logic        last_op;
	} op_t;

	// One result
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] start;
		logic [30:0] stop;
		logic [30:0] qlen;
		logic        last;
	} res_t;

	// All results of one operation, packed from slot 0
	typedef struct packed {
		res_t [MAX_RES-1:0] slot;
		logic [1:0]         cnt;
	} step_t;

	// Saturating position add
	function automatic logic [30:0] sat_add(input logic [30:0] a, input logic [27:0] b);
		logic [31:0] s;
		s = {1'b0, a} + {4'b0, b};
		return s[31] ? POS_MAX : s[30:0];
	endfunction

	function automatic logic eats_ref(input logic [3:0] c);
		return c inside {OP_M, OP_D, OP_N, OP_EQ, OP_X};
	endfunction

	function automatic logic eats_query(input logic [3:0] c);
		return c inside {OP_M, OP_I, OP_S, OP_EQ, OP_X};
	endfunction

endpackage

>>> rtl/cigar_interval_extractor.sv
// Top level of the CIGAR interval extractor: input register, minimum flank
// register, record walker and result bank. Depends on cie_pkg, cie_step,
// cie_result_buf.
//
// Usage:
//   Operation channel (op_valid/op_stall): one CIGAR operation per transfer;
//   alignment_start is read on the first operation of a record, last_op ends
//   the record.
//   Result channel (res_valid/res_stall): one interval per transfer; last is
//   high on the final result caused by an operation. An operation gives zero
//   to three results (splice, its own interval, record summary).
//   Configuration channel (cfg_valid/cfg_ready): writes min_flank; always
//   ready; the user writes it only while the block is idle (not enforced).
// Path: an accepted operation passes the input register and then the
//   result bank before its first result is offered for transfer.
// Throughput: one operation per cycle while each gives at most one result and
//   the receiver does not stall; otherwise one result per cycle, set by the
//   single result port draining the bank. Result-less operations pass too.
// Reset: clears the record state and empties both registers; min_flank
//   returns to 3. When the receiver stalls, results hold, the bank fills,
//   and op_stall rises once the input register is also occupied.

module cigar_interval_extractor (
	input  logic        clk,
	input  logic        arst_n,
	// operation channel
	input  logic        op_valid,
	output logic        op_stall,
	input  logic [3:0]  op_code,
	input  logic [27:0] op_length,
	input  logic [30:0] alignment_start,
	input  logic        last_op,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  kind,
	output logic [31:0] interval_start,
	output logic [30:0] interval_end,
	output logic [30:0] query_length,
	output logic        last,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [27:0] min_flank
);
	import cie_pkg::*;

	logic        valid_s1;
	op_t         op_s1;
	logic [27:0] min_flank_q;
	logic        advance;
	step_t       step;
	res_t        res;

	// Input register takes a new operation when empty or moving on
	assign op_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!op_stall) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && !op_stall) begin
			op_s1.code        <= op_code;
			op_s1.length      <= op_length;
			op_s1.align_start <= alignment_start;
			op_s1.last_op     <= last_op;
		end
	end

	// Minimum flank register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_flank_q <= MIN_FLANK_RST;
		end else if (cfg_valid && cfg_ready) begin
			min_flank_q <= min_flank;
		end
	end

	cie_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.op        (op_s1),
		.min_flank (min_flank_q),
		.step      (step)
	);

	cie_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.step      (step),
		.advance   (advance),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Result fields
	assign kind           = res.kind;
	assign interval_start = res.start;
	assign interval_end   = res.stop;
	assign query_length   = res.qlen;
	assign last           = res.last;

endmodule

>>> rtl/cie_step.sv
// Record walker: holds the per-record position state and computes every
// result of the operation in the input register. Depends on cie_pkg.

module cie_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  cie_pkg::op_t   op,
	input  logic [27:0]    min_flank,
	output cie_pkg::step_t step
);
	import cie_pkg::*;

	logic [30:0] ref_pos_q;
	logic [30:0] query_cnt_q;
	logic [30:0] record_start_q;
	logic [3:0]  prev_code_q;
	logic [27:0] prev_length_q;
	logic [3:0]  prev2_code_q;
	logic [27:0] prev2_length_q;
	logic [1:0]  ops_seen_q;

	logic        first;
	logic [30:0] pos_in;
	logic [30:0] after;
	logic [30:0] rec_start;
	logic [30:0] qbase;
	logic [30:0] qnext;
	logic        splice;
	logic        has_own;
	res_t        r_spl;
	res_t        r_own;
	res_t        r_sum;

	// Positions before and after this operation
	assign first     = (ops_seen_q == 2'd0);
	assign pos_in    = first ? op.align_start : ref_pos_q;
	assign rec_start = first ? op.align_start : record_start_q;
	assign qbase     = first ? '0 : query_cnt_q;
	assign after     = eats_ref(op.code) ? sat_add(pos_in, op.length) : pos_in;
	assign qnext     = eats_query(op.code) ? sat_add(qbase, op.length) : qbase;

	// Skip flanked by two long enough matches, decided on the second match
	assign splice = (ops_seen_q == 2'd2) && (prev_code_q == OP_N) &&
	                (prev2_code_q == OP_M) && (op.code == OP_M) &&
	                (prev2_length_q >= min_flank) && (op.length >= min_flank);

	assign has_own = (op.code == OP_M) || (op.code == OP_D) || (op.code == OP_I);

	// Candidate results
	always_comb begin
		r_spl       = '0;
		r_spl.kind  = KIND_SPLICE;
		r_spl.start = {1'b0, pos_in} - {4'b0, prev_length_q};
		r_spl.stop  = pos_in;

		r_own = '0;
		case (op.code)
			OP_M: begin
				r_own.kind  = KIND_MATCH;
				r_own.start = {1'b0, pos_in};
				r_own.stop  = after;
			end
			OP_D: begin
				r_own.kind  = KIND_DEL;
				r_own.start = {1'b0, pos_in};
				r_own.stop  = after;
			end
			OP_I: begin
				// two-base window around the position; -1 at position zero
				r_own.kind  = KIND_INS;
				r_own.start = {1'b0, pos_in} - 32'd1;
				r_own.stop  = sat_add(pos_in, 28'd1);
			end
			default: r_own = '0;
		endcase

		r_sum       = '0;
		r_sum.kind  = KIND_SUMM;
		r_sum.start = {1'b0, rec_start};
		r_sum.stop  = after;
		r_sum.qlen  = qnext;
	end

	// Pack results in order: splice, own interval, summary
	always_comb begin
		logic [1:0] n;
		n    = 2'd0;
		step = '0;
		if (splice) begin
			step.slot[n] = r_spl;
			n = n + 2'd1;
		end
		if (has_own) begin
			step.slot[n] = r_own;
			n = n + 2'd1;
		end
		if (op.last_op) begin
			step.slot[n] = r_sum;
			n = n + 2'd1;
		end
		if (n != 2'd0) begin
			step.slot[n - 2'd1].last = 1'b1;
		end
		step.cnt = n;
	end

	// State update when the operation moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_pos_q      <= '0;
			query_cnt_q    <= '0;
			record_start_q <= '0;
			prev_code_q    <= '0;
			prev_length_q  <= '0;
			prev2_code_q   <= '0;
			prev2_length_q <= '0;
			ops_seen_q     <= '0;
		end else if (advance) begin
			ref_pos_q      <= after;
			query_cnt_q    <= qnext;
			record_start_q <= rec_start;
			prev2_code_q   <= prev_code_q;
			prev2_length_q <= prev_length_q;
			prev_code_q    <= op.code;
			prev_length_q  <= op.length;
			if (op.last_op) begin
				ops_seen_q <= 2'd0;
			end else if (ops_seen_q != 2'd2) begin
				ops_seen_q <= ops_seen_q + 2'd1;
			end
		end
	end

endmodule

>>> rtl/cie_result_buf.sv
// Result register bank: holds the up to three results of one operation and
// hands them out one transfer at a time. Depends on cie_pkg.

module cie_result_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  cie_pkg::step_t step,
	output logic           advance,
	output logic           res_valid,
	input  logic           res_stall,
	output cie_pkg::res_t  res
);
	import cie_pkg::*;

	res_t [MAX_RES-1:0] bank_s2;
	logic [1:0]         cnt_q;
	logic [1:0]         idx_q;
	logic               xfer;
	logic               final_xfer;
	logic               free;

	// Bank can reload when empty or when its final result leaves now
	assign res_valid  = (cnt_q != 2'd0);
	assign xfer       = res_valid && !res_stall;
	assign final_xfer = xfer && (idx_q == cnt_q - 2'd1);
	assign free       = !res_valid || final_xfer;
	assign advance    = free && in_valid;
	assign res        = bank_s2[idx_q];

	// Count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (free) begin
			cnt_q <= in_valid ? step.cnt : 2'd0;
			idx_q <= '0;
		end else if (xfer) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (free) begin
			bank_s2 <= step.slot;
		end
	end

	// Pointer stays inside the loaded results
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> idx_q < cnt_q)
		else $error("result pointer past result count");

	// last flag marks exactly the final result of an operation
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.last == (idx_q == cnt_q - 2'd1)))
		else $error("last flag does not match final result");

	// A non-final transfer is followed by the next result of the same operation
	a_next_res: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !final_xfer) |=> (res_valid && idx_q == $past(idx_q) + 2'd1))
		else $error("result dropped inside an operation");

	// No operation moves on while results are still pending
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !final_xfer) |-> !advance)
		else $error("bank reloaded with results pending");

endmodule
